// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle implication failed");

`endif

// ----- hw/rtl/heu_pkg.sv -----
`default_nettype none

package heu_pkg;

    // Parser phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TAG  = 3'd1;
    localparam logic [2:0] PH_ENT  = 3'd2;
    localparam logic [2:0] PH_HASH = 3'd3;
    localparam logic [2:0] PH_DEC  = 3'd4;
    localparam logic [2:0] PH_HEX  = 3'd5;

    localparam int NUM_PAT    = 7;
    localparam int PAT_MAX    = 6;
    localparam int HELD_DEPTH = 5;
    localparam int EMIT_DEPTH = HELD_DEPTH + 1;

    // Pattern indices
    localparam logic [2:0] PAT_BR = 3'd0;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [6:0] ALIVE_TAG = 7'h07;
    localparam logic [6:0] ALIVE_ENT = 7'h78;

    // Pattern text, already folded to lower case
    localparam logic [7:0] PAT_CHARS [NUM_PAT][PAT_MAX] = '{
        '{8'h3C, 8'h62, 8'h72, 8'h2F, 8'h3E, 8'h00},   // <br/>
        '{8'h3C, 8'h73, 8'h71, 8'h2F, 8'h3E, 8'h00},   // <sq/>
        '{8'h3C, 8'h64, 8'h71, 8'h2F, 8'h3E, 8'h00},   // <dq/>
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}    // &quot;
    };

    localparam logic [2:0] PAT_LEN [NUM_PAT] = '{
        3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd6
    };

    typedef struct packed {
        logic accept;   // take an input beat, load the emit buffer
        logic push;     // move the next emit byte into the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;     // output register empty or being taken
        logic drain_last;   // next push is the last byte of the run
        logic has_result;   // the offered input yields at least one byte
    } t_status;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h41:8'h5A]}) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    // First replacement byte of a completed pattern
    function automatic logic [7:0] repl_byte(input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0: r = CH_CR;
            3'd1: r = CH_SQUOT;
            3'd2: r = CH_DQUOT;
            3'd3: r = CH_AMP;
            3'd4: r = CH_LT;
            3'd5: r = CH_GT;
            default: r = CH_DQUOT;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/heu_ctrl.sv -----
`default_nettype none

module heu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  heu_pkg::t_status      i_status,
    output logic                  o_in_ready,
    output heu_pkg::t_cmd         o_cmd
);

    localparam logic [0:0] ST_IDLE  = 1'b0;
    localparam logic [0:0] ST_DRAIN = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    always_comb begin
        o_cmd.push = (r_state == ST_DRAIN) && i_status.out_free;
        // Take the next beat while the final byte of a run moves out
        o_in_ready = (r_state == ST_IDLE) || (o_cmd.push && i_status.drain_last);
        o_cmd.accept = i_in_valid && o_in_ready;

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_status.has_result) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (o_cmd.accept) begin
                    n_state = i_status.has_result ? ST_DRAIN : ST_IDLE;
                end else if (o_cmd.push && i_status.drain_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/heu_datapath.sv -----
`default_nettype none

module heu_datapath (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  heu_pkg::t_cmd     i_cmd,
    output heu_pkg::t_status  o_status,
    input  wire logic [7:0]   i_text_byte,
    input  wire logic         i_end,
    input  wire logic         i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_text_done
);

    // Parser state
    logic [2:0] r_phase, n_phase;
    logic [2:0] r_hcnt,  n_hcnt;
    logic [6:0] r_alive, n_alive;
    logic [7:0] r_accum, n_accum;
    logic [7:0] r_held [heu_pkg::HELD_DEPTH];
    logic [7:0] n_held [heu_pkg::HELD_DEPTH];

    // Emit buffer and drain
    logic [7:0] r_em [heu_pkg::EMIT_DEPTH];
    logic [2:0] r_em_cnt;
    logic       r_em_end;
    logic [2:0] r_idx;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_done;

    // Step decode
    logic [7:0] b;
    logic [2:0] p;
    logic [6:0] alive_m;
    logic       done_hit;
    logic [2:0] done_k;
    logic       restart;
    logic       lit_mode;
    logic [2:0] lit_p;
    logic       lit_b;
    logic [7:0] sp0;
    logic [7:0] sp1;
    logic [2:0] sp_n;
    logic [2:0] em_cnt;

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h61) begin
            r = c - 8'd87;
        end else if (c >= 8'h41) begin
            r = c - 8'd55;
        end else begin
            r = c - heu_pkg::CH_ZERO;
        end
        return r;
    endfunction

    always_comb begin
        b        = i_text_byte;
        p        = r_hcnt;
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_alive  = r_alive;
        n_accum  = r_accum;
        n_held   = r_held;
        restart  = 1'b0;
        lit_mode = 1'b1;
        lit_p    = 3'd0;
        lit_b    = 1'b0;
        sp0      = 8'd0;
        sp1      = heu_pkg::CH_LF;
        sp_n     = 3'd0;
        alive_m  = 7'd0;
        done_hit = 1'b0;
        done_k   = 3'd0;

        for (int k = 0; k < heu_pkg::NUM_PAT; k++) begin
            if (r_alive[k] && (p < heu_pkg::PAT_LEN[k])
                    && (heu_pkg::fold(b) == heu_pkg::PAT_CHARS[k][p])) begin
                alive_m[k] = 1'b1;
            end
        end
        // Lowest completed pattern wins
        for (int k = heu_pkg::NUM_PAT - 1; k >= 0; k--) begin
            if (alive_m[k] && ((p + 3'd1) == heu_pkg::PAT_LEN[k])) begin
                done_hit = 1'b1;
                done_k   = 3'(k);
            end
        end

        case (r_phase)
            heu_pkg::PH_TAG, heu_pkg::PH_ENT: begin
                if ((r_phase == heu_pkg::PH_ENT) && (p == 3'd1)
                        && (b == heu_pkg::CH_HASH)) begin
                    n_phase = heu_pkg::PH_HASH;
                    n_hcnt  = 3'd0;
                    n_alive = 7'd0;
                    n_accum = 8'd0;
                end else if (done_hit) begin
                    lit_mode = 1'b0;
                    sp0      = heu_pkg::repl_byte(done_k);
                    sp_n     = (done_k == heu_pkg::PAT_BR) ? 3'd2 : 3'd1;
                    n_phase  = heu_pkg::PH_IDLE;
                    n_hcnt   = 3'd0;
                    n_alive  = 7'd0;
                    n_accum  = 8'd0;
                end else if ((alive_m != 7'd0) && (p < 3'(heu_pkg::HELD_DEPTH))) begin
                    n_held[p] = b;
                    n_hcnt    = p + 3'd1;
                    n_alive   = alive_m;
                    if (i_end) begin
                        lit_p = p;
                        lit_b = 1'b1;
                    end
                end else begin
                    lit_p   = p;
                    restart = 1'b1;
                end
            end
            heu_pkg::PH_HASH: begin
                if (b == heu_pkg::CH_X) begin
                    n_phase = heu_pkg::PH_HEX;
                    n_accum = 8'd0;
                end else if (b == heu_pkg::CH_SEMI) begin
                    n_phase = heu_pkg::PH_IDLE;
                    n_hcnt  = 3'd0;
                    n_alive = 7'd0;
                    n_accum = 8'd0;
                end else begin
                    n_phase = heu_pkg::PH_DEC;
                    n_accum = b - heu_pkg::CH_ZERO;
                end
            end
            heu_pkg::PH_DEC, heu_pkg::PH_HEX: begin
                if (b == heu_pkg::CH_SEMI) begin
                    if (r_accum != 8'd0) begin
                        lit_mode = 1'b0;
                        sp0      = r_accum;
                        sp_n     = 3'd1;
                    end
                    n_phase = heu_pkg::PH_IDLE;
                    n_hcnt  = 3'd0;
                    n_alive = 7'd0;
                    n_accum = 8'd0;
                end else if (r_phase == heu_pkg::PH_DEC) begin
                    n_accum = {r_accum[4:0], 3'b000} + {r_accum[6:0], 1'b0}
                              + b - heu_pkg::CH_ZERO;
                end else begin
                    n_accum = {r_accum[3:0], 4'b0000} + hex_digit(b);
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        // Drop the old match; the current byte opens a new one or is literal
        if (restart) begin
            n_phase = heu_pkg::PH_IDLE;
            n_hcnt  = 3'd0;
            n_alive = 7'd0;
            n_accum = 8'd0;
            if (((b == heu_pkg::CH_LT) || (b == heu_pkg::CH_AMP)) && !i_end) begin
                n_phase   = (b == heu_pkg::CH_LT) ? heu_pkg::PH_TAG : heu_pkg::PH_ENT;
                n_alive   = (b == heu_pkg::CH_LT) ? heu_pkg::ALIVE_TAG : heu_pkg::ALIVE_ENT;
                n_held[0] = b;
                n_hcnt    = 3'd1;
            end else begin
                lit_b = 1'b1;
            end
        end

        // End of text: flush an open numeric reference, return to idle
        if (i_end) begin
            if (((n_phase == heu_pkg::PH_DEC) || (n_phase == heu_pkg::PH_HEX))
                    && (n_accum != 8'd0)) begin
                lit_mode = 1'b0;
                sp0      = n_accum;
                sp_n     = 3'd1;
            end
            n_phase = heu_pkg::PH_IDLE;
            n_hcnt  = 3'd0;
            n_alive = 7'd0;
            n_accum = 8'd0;
        end

        em_cnt = lit_mode ? (lit_p + {2'b00, lit_b}) : sp_n;
    end

    always_comb begin
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.drain_last = ((r_idx + 3'd1) == r_em_cnt);
        o_status.has_result = (em_cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= heu_pkg::PH_IDLE;
            r_hcnt      <= 3'd0;
            r_alive     <= 7'd0;
            r_accum     <= 8'd0;
            r_em_cnt    <= 3'd0;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_phase  <= n_phase;
                r_hcnt   <= n_hcnt;
                r_alive  <= n_alive;
                r_accum  <= n_accum;
                r_em_cnt <= em_cnt;
                r_idx    <= 3'd0;
            end else if (i_cmd.push) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_held   <= n_held;
            r_em_end <= i_end;
            if (lit_mode) begin
                for (int i = 0; i < heu_pkg::HELD_DEPTH; i++) begin
                    r_em[i] <= (3'(i) < lit_p) ? r_held[i] : b;
                end
                r_em[heu_pkg::EMIT_DEPTH - 1] <= b;
            end else begin
                r_em[0] <= sp0;
                r_em[1] <= sp1;
            end
        end
        if (i_cmd.push) begin
            r_out_byte <= r_em[r_idx];
            r_out_last <= o_status.drain_last;
            r_out_done <= o_status.drain_last && r_em_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;
    assign o_text_done = r_out_done;

endmodule

`default_nettype wire

// ----- hw/rtl/html_entity_unescaper_top.sv -----
// Channel   | Dir | tdata          | tlast        | tuser
// ----------+-----+----------------+--------------+-----------
// s_axis    | in  | text_byte[7:0] | end_of_text  | -
// m_axis    | out | out_byte[7:0]  | run_last     | text_done
//
// An input beat giving n decoded bytes (n from 0 to 6) has them moved out one
// at a time by the drain. The next input beat is taken in the cycle its
// predecessor's final byte enters the output register, set by the single drain
// pointer over the emit buffer. Reset is synchronous, active low, and returns the
// parser to idle with no match pending. A stalled output holds its byte and
// stops the drain; the input side waits until the run is out.
`default_nettype none

module html_entity_unescaper_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // run_last
    output logic [0:0]      m_axis_tuser    // [0] text_done
);

    heu_pkg::t_cmd    cmd;
    heu_pkg::t_status status;

    // Controller: decides when to take a beat and when to advance the drain
    heu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Datapath: pattern match, held bytes, numeric accumulator, emit buffer
    // and the output register
    heu_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_text_byte (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_run_last  (m_axis_tlast),
        .o_text_done (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

// ----- hw/rtl/heu_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module heu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [0:0] m_axis_tuser
);

    // A stalled output beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // End of text only on the last byte of a run
    `ASSERT_IMPLIES(a_done_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

    // A run does not break up: after a taken non-final byte the next follows
    `ASSERT_NEXT(a_run_gapless, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

    // Nothing on the output right after reset
    `ASSERT_IMPLIES(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid)

endmodule

bind html_entity_unescaper_top heu_checker u_heu_checker (.*);

`default_nettype wire
